/* rtl/core/uart_8n1_tx_rx_ticked_macros.svh */
// ----------------------------------------------------------------------------
// UART 8N1 transceiver assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UART_8N1_TX_RX_TICKED_MACROS_SVH
`define UART_8N1_TX_RX_TICKED_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U8TR_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U8TR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/u8tr_pkg.sv */
// ----------------------------------------------------------------------------
// UART 8N1 transceiver package
// Payload types, register map and fixed frame constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u8tr_pkg;

	// One input transfer: one timer tick.
	typedef struct packed {
		logic       rx_line;
		logic       send;
		logic [7:0] send_byte;
	} u8tr_item_t;

	// One result transfer per tick.
	typedef struct packed {
		logic       tx_line;
		logic       tx_drive;
		logic       tx_busy;
		logic       tx_done;
		logic       rx_valid;
		logic [7:0] rx_byte;
	} u8tr_res_t;

	// Single-bit mode controls shared by both directions.
	typedef struct packed {
		logic inverted;
		logic one_wire;
		logic tx_enable;
		logic rx_enable;
	} u8tr_flags_t;

	// Transmitter outputs for one tick.
	typedef struct packed {
		logic line;
		logic drive;
		logic busy;
		logic done;
	} u8tr_tx_res_t;

	// Register map.
	localparam int ADDR_W = 5;
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_BIT_LENGTH       = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_START_BIT_LENGTH = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INVERTED         = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_ONE_WIRE         = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_TX_ENABLE        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_RX_ENABLE        = 3'd5;

	// Register reset values.
	localparam logic [15:0] BIT_LENGTH_RST       = 16'd104;
	localparam logic [15:0] START_BIT_LENGTH_RST = 16'd104;

	// Frame shape: start plus eight data bits, then the stop bit.
	localparam logic [3:0] TX_FRAME_BITS = 4'd9;
	localparam logic [3:0] RX_DATA_BITS  = 4'd8;

endpackage

/* rtl/core/u8tr_tx.sv */
// ----------------------------------------------------------------------------
// UART 8N1 transmitter
// Frame timing and bit shifting, advanced by one tick per result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tr_tx #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        send,
	input  logic [7:0]                  send_byte,
	input  u8tr_pkg::u8tr_flags_t       flags,
	input  logic [TICK_COUNT_WIDTH-1:0] bit_len,
	input  logic [TICK_COUNT_WIDTH-1:0] start_len,
	output u8tr_pkg::u8tr_tx_res_t      res
);
	import u8tr_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;

	logic [3:0]    bits_left_q, bits_left_n;
	logic [7:0]    shift_q, shift_n;
	logic [TW-1:0] timer_q, timer_n;
	logic          level_q, level_n;
	logic          busy, done, idle_lvl;

	assign idle_lvl = ~flags.inverted;

	// Bit timing first, then a send request, then the idle level.
	always_comb begin
		bits_left_n = bits_left_q;
		shift_n     = shift_q;
		timer_n     = timer_q;
		level_n     = level_q;
		done        = 1'b0;
		if (!flags.tx_enable) begin
			bits_left_n = 4'd0;
			timer_n     = '0;
		end else if (bits_left_q != 4'd0 || timer_q != '0) begin
			if (timer_q != '0) begin
				timer_n = timer_q - TW'(1);
			end
			if (timer_n == '0) begin
				if (bits_left_q > 4'd1) begin
					level_n     = shift_q[0];
					shift_n     = {1'b0, shift_q[7:1]};
					timer_n     = bit_len;
					bits_left_n = bits_left_q - 4'd1;
				end else if (bits_left_q == 4'd1) begin
					level_n     = idle_lvl;
					timer_n     = bit_len;
					bits_left_n = 4'd0;
				end else begin
					done = 1'b1;
				end
			end
		end
		busy = (bits_left_n != 4'd0) || (timer_n != '0);
		if (send && !busy) begin
			if (flags.tx_enable) begin
				shift_n     = flags.inverted ? ~send_byte : send_byte;
				bits_left_n = TX_FRAME_BITS;
				level_n     = flags.inverted;
				timer_n     = start_len;
				busy        = 1'b1;
			end else begin
				done = 1'b1;
			end
		end
		if (!busy) begin
			level_n = idle_lvl;
		end
	end

	assign res.line  = level_n;
	assign res.drive = flags.tx_enable & (~flags.one_wire | busy);
	assign res.busy  = busy;
	assign res.done  = done;

	// Transmitter state advances once per tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= 4'd0;
			shift_q     <= 8'd0;
			timer_q     <= '0;
			level_q     <= 1'b1;
		end else if (step) begin
			bits_left_q <= bits_left_n;
			shift_q     <= shift_n;
			timer_q     <= timer_n;
			level_q     <= level_n;
		end
	end

endmodule

/* rtl/core/u8tr_rx.sv */
// ----------------------------------------------------------------------------
// UART 8N1 receiver
// Start-edge detection, mid-bit sampling and byte assembly, one tick a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u8tr_rx #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        rx_line,
	input  logic                        tx_busy,
	input  u8tr_pkg::u8tr_flags_t       flags,
	input  logic [TICK_COUNT_WIDTH-1:0] bit_len,
	output logic                        rx_valid,
	output logic [7:0]                  rx_byte
);
	import u8tr_pkg::*;

	localparam int TW = TICK_COUNT_WIDTH;

	logic          active_q, active_n;
	logic [3:0]    count_q, count_n;
	logic [7:0]    shift_q, shift_n;
	logic [TW:0]   timer_q, timer_n;
	logic          prev_q;
	logic          cur, prev, armed;

	assign cur   = rx_line ^ flags.inverted;
	assign prev  = prev_q ^ flags.inverted;
	assign armed = flags.rx_enable & ~(flags.one_wire & tx_busy);

	// Sample 1.5 bit lengths after the start edge, then every bit length.
	always_comb begin
		active_n = active_q;
		count_n  = count_q;
		shift_n  = shift_q;
		timer_n  = timer_q;
		rx_valid = 1'b0;
		rx_byte  = 8'd0;
		if (!armed) begin
			active_n = 1'b0;
		end else if (active_q) begin
			if (timer_q != '0) begin
				timer_n = timer_q - (TW+1)'(1);
			end
			if (timer_n == '0) begin
				shift_n = {cur, shift_q[7:1]};
				count_n = count_q + 4'd1;
				timer_n = {1'b0, bit_len};
				if (count_n >= RX_DATA_BITS) begin
					rx_valid = 1'b1;
					rx_byte  = shift_n;
					active_n = 1'b0;
				end
			end
		end else if (prev && !cur) begin
			active_n = 1'b1;
			timer_n  = {1'b0, bit_len} + {2'b00, bit_len[TW-1:1]};
			count_n  = 4'd0;
			shift_n  = 8'd0;
		end
	end

	// Receiver state advances once per tick; the raw line level is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= 4'd0;
			shift_q  <= 8'd0;
			timer_q  <= '0;
			prev_q   <= 1'b1;
		end else if (step) begin
			active_q <= active_n;
			count_q  <= count_n;
			shift_q  <= shift_n;
			timer_q  <= timer_n;
			prev_q   <= rx_line;
		end
	end

endmodule

/* rtl/core/uart_8n1_tx_rx_ticked.sv */
// ----------------------------------------------------------------------------
// UART 8N1 transceiver, timer-ticked
// Register bank, tick pipeline and the transmitter and receiver cores.
// ----------------------------------------------------------------------------
// Usage:
// Each transfer on the item channel (item_valid, item_stall, item) is one timer
// tick carrying the sampled receive line and an optional byte to send. Each
// tick yields exactly one transfer on the result channel (res_valid,
// res_stall, res) with the transmit line level, drive enable, busy and done
// flags, and a received byte when one completes.
// Each tick is held in the input register, then the transmitter and receiver
// update in one pass into the result register. Throughput is one tick per cycle
// while res_stall is low; the bit timers are plain counters that step once per
// transfer.
// While the result register holds an untaken result, one more item is taken
// into the input register; after that item_stall rises until res_stall drops.
// Reset clears both stages, idles the line (high unless inverted) and loads the
// register defaults. Registers are to be written through the APB port only
// while no ticks are in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_8n1_tx_rx_ticked_macros.svh"

module uart_8n1_tx_rx_ticked #(
	parameter int TICK_COUNT_WIDTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  u8tr_pkg::u8tr_item_t         item,
	output logic                         res_valid,
	input  logic                         res_stall,
	output u8tr_pkg::u8tr_res_t          res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [u8tr_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import u8tr_pkg::*;

	localparam int TW   = TICK_COUNT_WIDTH;
	localparam int MAXW = (TW > 16) ? TW : 16;

	logic [15:0]          bit_length_q, start_bit_length_q;
	u8tr_flags_t          flags_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [TW-1:0]        bit_len, start_len;

	logic         valid_s1;
	u8tr_item_t   item_s1;
	logic         res_valid_s2;
	u8tr_res_t    res_s2;
	logic         adv;
	u8tr_tx_res_t tx_res;
	logic         rx_valid;
	logic [7:0]   rx_byte;

	// A zero length acts as one; a length beyond the counter saturates.
	function automatic logic [TW-1:0] eff_len(input logic [15:0] v);
		logic [MAXW-1:0] ext;
		logic [MAXW-1:0] top;
		ext = MAXW'(v);
		top = MAXW'({TW{1'b1}});
		if (v == 16'd0) begin
			eff_len = TW'(1);
		end else if (ext > top) begin
			eff_len = top[TW-1:0];
		end else begin
			eff_len = ext[TW-1:0];
		end
	endfunction

	// Configuration port.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_length_q       <= BIT_LENGTH_RST;
			start_bit_length_q <= START_BIT_LENGTH_RST;
			flags_q.inverted   <= 1'b0;
			flags_q.one_wire   <= 1'b0;
			flags_q.tx_enable  <= 1'b1;
			flags_q.rx_enable  <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_BIT_LENGTH:       bit_length_q       <= pwdata[15:0];
				REG_START_BIT_LENGTH: start_bit_length_q <= pwdata[15:0];
				REG_INVERTED:         flags_q.inverted   <= pwdata[0];
				REG_ONE_WIRE:         flags_q.one_wire   <= pwdata[0];
				REG_TX_ENABLE:        flags_q.tx_enable  <= pwdata[0];
				REG_RX_ENABLE:        flags_q.rx_enable  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_BIT_LENGTH:       prdata = {16'd0, bit_length_q};
			REG_START_BIT_LENGTH: prdata = {16'd0, start_bit_length_q};
			REG_INVERTED:         prdata = {31'd0, flags_q.inverted};
			REG_ONE_WIRE:         prdata = {31'd0, flags_q.one_wire};
			REG_TX_ENABLE:        prdata = {31'd0, flags_q.tx_enable};
			REG_RX_ENABLE:        prdata = {31'd0, flags_q.rx_enable};
			default:              prdata = 32'd0;
		endcase
	end

	assign bit_len   = eff_len(bit_length_q);
	assign start_len = eff_len(start_bit_length_q);

	// The tick moves into the result register when that register is empty or is being emptied by the consumer.
	assign adv        = valid_s1 & (~res_valid_s2 | ~res_stall);
	assign item_stall = valid_s1 & ~adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	// Transmitter and receiver cores.
	u8tr_tx #(
		.TICK_COUNT_WIDTH(TW)
	) u_tx (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv),
		.send      (item_s1.send),
		.send_byte (item_s1.send_byte),
		.flags     (flags_q),
		.bit_len   (bit_len),
		.start_len (start_len),
		.res       (tx_res)
	);

	u8tr_rx #(
		.TICK_COUNT_WIDTH(TW)
	) u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.rx_line  (item_s1.rx_line),
		.tx_busy  (tx_res.busy),
		.flags    (flags_q),
		.bit_len  (bit_len),
		.rx_valid (rx_valid),
		.rx_byte  (rx_byte)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (adv) begin
			res_valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.tx_line  <= tx_res.line;
			res_s2.tx_drive <= tx_res.drive;
			res_s2.tx_busy  <= tx_res.busy;
			res_s2.tx_done  <= tx_res.done;
			res_s2.rx_valid <= rx_valid;
			res_s2.rx_byte  <= rx_byte;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	// A blocked tick stays in the input register.
	`U8TR_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1, "blocked tick was lost")
	// A received byte is only reported with its valid flag.
	`U8TR_ASSERT_SAME(a_rx_byte_zero, res_valid && !res.rx_valid, res.rx_byte == 8'd0,
		"rx_byte set without rx_valid")
	// A busy transmitter that is enabled always drives the line.
	`U8TR_ASSERT_SAME(a_busy_drive, adv && tx_res.busy && flags_q.tx_enable, tx_res.drive,
		"busy transmitter released the line")

endmodule
